[rtl/core/case_insensitive_substring_search_unit_macros.svh]
// Assertion macros for the case-insensitive substring search unit
`ifndef CASE_INSENSITIVE_SUBSTRING_SEARCH_UNIT_MACROS_SVH
`define CASE_INSENSITIVE_SUBSTRING_SEARCH_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CISSU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cissu assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define CISSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cissu assertion failed");

`endif

[rtl/core/cissu_pkg.sv]
// Shared types and constants for the case-insensitive substring search unit
`default_nettype none

package cissu_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_HAY    = 2'd1,
    OP_END    = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_HAY    = 3'd1,
    KIND_END    = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_IGNORE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_MATCH   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_PATTERN = 2'd3
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  localparam logic [7:0]  NUL_BYTE     = 8'h00;
  localparam logic [7:0]  UPPER_A      = 8'h41;
  localparam logic [7:0]  UPPER_Z      = 8'h5A;
  localparam logic [7:0]  CASE_DELTA   = 8'h20;
  localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

endpackage

`default_nettype wire

[rtl/core/case_insensitive_substring_search_unit.sv]
// A request taken goes into the queue; the engine pops it and registers its result.
// One request per cycle unless a stall is raised; the match vector is updated by shift-and.
// A two-entry queue parts the front end from the engine; stall rises only when it is full.
// Reset clears queue, pattern length, match vector, position and result valid.
// Pattern bytes are not reset and are read only below the pattern length.
`default_nettype none

module case_insensitive_substring_search_unit #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [15:0]      match_offset_o,
  output logic             offset_saturated_o
);
  import cissu_pkg::*;

  item_t         front_item;
  item_t         head_item;
  queue_status_t q_status;
  logic          pop;
  logic          accept;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  cissu_front u_front (
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .item_o      (front_item)
  );

  cissu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (front_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .status_o    (q_status)
  );

  cissu_back #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head_item),
    .q_status_i         (q_status),
    .out_stall_i        (out_stall_i),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .match_offset_o     (match_offset_o),
    .offset_saturated_o (offset_saturated_o)
  );

`include "case_insensitive_substring_search_unit_macros.svh"

  `CISSU_ASSERT_NEXT(a_accept_queued, accept, !q_status.empty)
  `CISSU_ASSERT_NEXT(a_pop_gives_result, pop, out_valid_o)
  `CISSU_ASSERT_SAME(a_result_from_pop, $rose(out_valid_o), $past(pop))

endmodule

`default_nettype wire

[rtl/core/cissu_front.sv]
// Front end: case folding and request classification
`default_nettype none

module cissu_front (
  input  wire logic [1:0]     opcode_i,
  input  wire logic [7:0]     data_byte_i,
  output cissu_pkg::item_t    item_o
);
  import cissu_pkg::*;

  logic [7:0] folded;

  always_comb begin
    folded = data_byte_i;
    if (data_byte_i >= UPPER_A && data_byte_i <= UPPER_Z) begin
      folded = data_byte_i + CASE_DELTA;
    end
  end

  always_comb begin
    item_o.ch   = folded;
    item_o.kind = KIND_IGNORE;
    unique case (opcode_e'(opcode_i))
      OP_APPEND: begin
        item_o.kind = (folded == NUL_BYTE) ? KIND_IGNORE : KIND_APPEND;
      end
      OP_HAY: begin
        item_o.kind = (folded == NUL_BYTE) ? KIND_END : KIND_HAY;
      end
      OP_END: begin
        item_o.kind = KIND_END;
      end
      OP_CLEAR: begin
        item_o.kind = KIND_CLEAR;
      end
      default: begin
        item_o.kind = KIND_IGNORE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/cissu_queue.sv]
// Two-entry queue between front end and search engine
`default_nettype none

module cissu_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire cissu_pkg::item_t    push_item_i,
  input  wire logic                pop_i,
  output cissu_pkg::item_t         head_o,
  output cissu_pkg::queue_status_t status_o
);
  import cissu_pkg::*;

  item_t                  entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/cissu_back.sv]
// Search engine: pattern store, shift-and match vector and result register
`default_nettype none

module cissu_back #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cissu_pkg::item_t         head_i,
  input  wire cissu_pkg::queue_status_t q_status_i,
  input  wire logic                     out_stall_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [15:0]                   match_offset_o,
  output logic                          offset_saturated_o
);
  import cissu_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int WIDE_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};

  logic [7:0]               pat_q [MAX_PATTERN];
  logic [LEN_W-1:0]         len_q, len_d;
  logic [MAX_PATTERN-1:0]   vec_q, vec_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     mr_q, mr_d;

  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic [15:0]              offset_q, offset_d;
  logic                     sat_q, sat_d;

  logic                     fire;
  logic                     pat_we;
  logic [IDX_W-1:0]         wr_idx;
  logic [IDX_W-1:0]         top_idx;
  logic [MAX_PATTERN-1:0]   mask;
  logic [MAX_PATTERN-1:0]   vec_next;
  logic [POSITION_BITS-1:0] back_pos;
  logic [POSITION_BITS-1:0] off;
  logic [WIDE_W-1:0]        off_wide;
  logic                     clipped;

  assign fire    = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o   = fire;
  assign wr_idx  = len_q[IDX_W-1:0];
  assign top_idx = IDX_W'(len_q - LEN_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      mask[i] = (LEN_W'(i) < len_q) && (pat_q[i] == head_i.ch);
    end
  end

  assign vec_next = ((vec_q << 1) | MAX_PATTERN'(1)) & mask;
  assign back_pos = POSITION_BITS'(len_q - LEN_W'(1));
  assign off      = (pos_q >= back_pos) ? pos_q - back_pos : '0;

  always_comb begin
    len_d    = len_q;
    vec_d    = vec_q;
    pos_d    = pos_q;
    mr_d     = mr_q;
    pat_we   = 1'b0;
    status_d = ST_NONE;
    off_wide = '0;
    unique case (head_i.kind)
      KIND_APPEND: begin
        if (len_q < LEN_W'(MAX_PATTERN)) begin
          pat_we   = 1'b1;
          len_d    = len_q + LEN_W'(1);
          vec_d    = '0;
          pos_d    = '0;
          mr_d     = 1'b0;
          status_d = ST_PATTERN;
        end
      end
      KIND_CLEAR: begin
        len_d    = '0;
        vec_d    = '0;
        pos_d    = '0;
        mr_d     = 1'b0;
        status_d = ST_PATTERN;
      end
      KIND_END: begin
        if (!mr_q) begin
          status_d = (len_q == '0) ? ST_MATCH : ST_NOMATCH;
        end
        vec_d = '0;
        pos_d = '0;
        mr_d  = 1'b0;
      end
      KIND_HAY: begin
        if (!mr_q) begin
          if (len_q == '0) begin
            status_d = ST_MATCH;
            mr_d     = 1'b1;
          end else begin
            vec_d = vec_next;
            if (vec_next[top_idx]) begin
              off_wide = WIDE_W'(off);
              status_d = ST_MATCH;
              mr_d     = 1'b1;
            end
            if (pos_q != POS_LIMIT) begin
              pos_d = pos_q + POSITION_BITS'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
    clipped  = off_wide > WIDE_W'(OFFSET_MAX);
    offset_d = clipped ? OFFSET_MAX : off_wide[15:0];
    sat_d    = clipped || (pos_d == POS_LIMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      vec_q       <= '0;
      pos_q       <= '0;
      mr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        len_q <= len_d;
        vec_q <= vec_d;
        pos_q <= pos_d;
        mr_q  <= mr_d;
      end
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      offset_q <= offset_d;
      sat_q    <= sat_d;
    end
    if (fire && pat_we) begin
      pat_q[wr_idx] <= head_i.ch;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign match_offset_o     = offset_q;
  assign offset_saturated_o = sat_q;

endmodule

`default_nettype wire
